// ----- hw/rtl/srqt_pkg.sv -----
package srqt_pkg;

    // table size and result bound
    localparam int SRQT_CAPACITY = 16;
    localparam int MAX_RESULTS   = 16;

    // field widths
    localparam int KEY_W    = 48;
    localparam int SYS_W    = 16;
    localparam int IDX_IN_W = 8;
    localparam int LIMIT_W  = 7;
    localparam int TAKE_W   = $clog2(MAX_RESULTS + 1);

    // commands
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [KEY_W-1:0]    time_key;
        logic [SYS_W-1:0]    origin_id;
        logic [IDX_IN_W-1:0] entry_index;
        logic [KEY_W-1:0]    range_start;
        logic [KEY_W-1:0]    range_end;
        logic [LIMIT_W-1:0]  result_limit;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key_out;
        logic [SYS_W-1:0] system_out;
        logic             entry_valid;
        logic             last;
    } t_out;

    // which kind of result the output register takes
    typedef enum logic [1:0] {
        OUT_SIMPLE,
        OUT_MARK,
        OUT_ENTRY
    } t_out_sel;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     scan_start;
        logic     scan_from_idx;
        logic     scan_run;
        logic     shift_wr;
        logic     count_match;
        logic     select;
        logic     dec_count;
        logic     take_load;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic [1:0] status;
        logic       scan_done;
        logic       take_zero;
        logic       out_free;
        logic       last_entry;
    } t_sts;

endpackage

// ----- hw/rtl/srqt_ctrl.sv -----
module srqt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srqt_pkg::t_sts  i_sts,
    output srqt_pkg::t_cmd  o_cmd
);
    import srqt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SIMPLE = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_QCOUNT = 8'b0001_0000,
        S_QSEL   = 8'b0010_0000,
        S_QEMIT  = 8'b0100_0000,
        S_MARK   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.func)
                    FUNC_REMOVE: begin
                        if (i_sts.status == ST_OK) begin
                            o_cmd.scan_start    = 1'b1;
                            o_cmd.scan_from_idx = 1'b1;
                            n_state             = S_SHIFT;
                        end else begin
                            n_state = S_SIMPLE;
                        end
                    end
                    FUNC_QUERY: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_QCOUNT;
                    end
                    default: begin
                        n_state = S_SIMPLE;
                    end
                endcase
            end
            S_SIMPLE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_SIMPLE;
                    n_state        = S_IDLE;
                end
            end
            S_SHIFT: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_SIMPLE;
                end
            end
            S_QCOUNT: begin
                o_cmd.scan_run    = 1'b1;
                o_cmd.count_match = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.take_load = 1'b1;
                    if (i_sts.take_zero) begin
                        n_state = S_MARK;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_QSEL;
                    end
                end
            end
            S_QSEL: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.select   = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_QEMIT;
                end
            end
            S_QEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_ENTRY;
                    if (i_sts.last_entry) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_QSEL;
                    end
                end
            end
            S_MARK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_MARK;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/srqt_dp.sv -----
module srqt_dp #(
    parameter int CAPACITY = srqt_pkg::SRQT_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srqt_pkg::t_in  i_in_data,
    input  srqt_pkg::t_cmd i_cmd,
    output srqt_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srqt_pkg::t_out o_out_data
);
    import srqt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // latched transaction and table state
    t_in              r_in;
    logic [1:0]       r_status;
    logic [CNT_W-1:0] r_count;

    // entry store, one write and one registered read port
    logic [KEY_W-1:0] r_key_mem [CAPACITY];
    logic [SYS_W-1:0] r_sys_mem [CAPACITY];

    // scan pipeline
    logic [CNT_W-1:0] r_rd_addr;
    logic             r_rd_vld;
    logic [KEY_W-1:0] r_rd_key;
    logic [SYS_W-1:0] r_rd_sys;
    logic [IDX_W-1:0] r_rd_pos;

    // query state
    logic [CNT_W-1:0]  r_nmatch;
    logic              r_best_vld;
    logic [KEY_W-1:0]  r_best_key;
    logic [SYS_W-1:0]  r_best_sys;
    logic [IDX_W-1:0]  r_best_pos;
    logic              r_prev_vld;
    logic [KEY_W-1:0]  r_prev_key;
    logic [IDX_W-1:0]  r_prev_pos;
    logic [TAKE_W-1:0] r_take;
    logic [TAKE_W-1:0] r_emit;

    logic r_out_valid;
    t_out r_out;

    logic               rd_issue;
    logic               in_range;
    logic               after_prev;
    logic               better;
    logic               full;
    logic               bad_idx;
    logic               out_free;
    logic               add_commit;
    logic               shift_commit;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [SYS_W-1:0]   wr_sys;
    logic [LIMIT_W-1:0] take_a;
    logic [TAKE_W-1:0]  n_take;
    logic [TAKE_W-1:0]  emit_next;

    assign rd_issue   = i_cmd.scan_run && (r_rd_addr < r_count);
    assign in_range   = (r_rd_key >= r_in.range_start) && (r_rd_key <= r_in.range_end);
    // strictly after the last emitted entry in (key, position) order
    assign after_prev = !r_prev_vld || (r_rd_key > r_prev_key)
                        || ((r_rd_key == r_prev_key) && (r_rd_pos > r_prev_pos));
    assign better     = !r_best_vld || (r_rd_key < r_best_key);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign bad_idx    = (i_in_data.entry_index >= IDX_IN_W'(r_count));
    assign out_free   = !r_out_valid || i_out_ready;

    assign add_commit   = i_cmd.out_load && (i_cmd.out_sel == OUT_SIMPLE)
                          && (r_in.func == FUNC_ADD) && (r_status == ST_OK);
    assign shift_commit = i_cmd.shift_wr && r_rd_vld;

    assign wr_addr = shift_commit ? (r_rd_pos - IDX_W'(1)) : r_count[IDX_W-1:0];
    assign wr_key  = shift_commit ? r_rd_key : r_in.time_key;
    assign wr_sys  = shift_commit ? r_rd_sys : r_in.origin_id;

    always_comb begin
        take_a = (LIMIT_W'(r_nmatch) < r_in.result_limit) ? LIMIT_W'(r_nmatch)
                                                          : r_in.result_limit;
        n_take = (take_a < LIMIT_W'(MAX_RESULTS)) ? TAKE_W'(take_a) : TAKE_W'(MAX_RESULTS);
    end

    assign emit_next = r_emit + TAKE_W'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.func       = r_in.func;
        o_sts.status     = r_status;
        o_sts.scan_done  = (r_rd_addr >= r_count) && !r_rd_vld;
        o_sts.take_zero  = (n_take == '0);
        o_sts.out_free   = out_free;
        o_sts.last_entry = (emit_next == r_take);
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (add_commit || shift_commit) begin
            r_key_mem[wr_addr] <= wr_key;
            r_sys_mem[wr_addr] <= wr_sys;
        end
        if (rd_issue) begin
            r_rd_key <= r_key_mem[r_rd_addr[IDX_W-1:0]];
            r_rd_sys <= r_sys_mem[r_rd_addr[IDX_W-1:0]];
            r_rd_pos <= r_rd_addr[IDX_W-1:0];
        end
    end

    // transaction latch and status decode
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_in_data;
            case (i_in_data.func)
                FUNC_ADD:    r_status <= full ? ST_FULL : ST_OK;
                FUNC_REMOVE: r_status <= bad_idx ? ST_BAD_INDEX : ST_OK;
                default:     r_status <= ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (add_commit) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec_count) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // scan address and read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_addr <= i_cmd.scan_from_idx
                         ? (CNT_W'(r_in.entry_index) + CNT_W'(1)) : '0;
        end else if (rd_issue) begin
            r_rd_addr <= r_rd_addr + CNT_W'(1);
        end
    end

    // match count over the first pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_nmatch <= '0;
        end else if (i_cmd.count_match && r_rd_vld && in_range) begin
            r_nmatch <= r_nmatch + CNT_W'(1);
        end
    end

    // running minimum of each selection pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_best_vld <= 1'b0;
        end else if (i_cmd.select && r_rd_vld && in_range && after_prev && better) begin
            r_best_vld <= 1'b1;
            r_best_key <= r_rd_key;
            r_best_sys <= r_rd_sys;
            r_best_pos <= r_rd_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
        end else if (i_cmd.take_load) begin
            r_prev_vld <= 1'b0;
            r_take     <= n_take;
            r_emit     <= '0;
        end else if (i_cmd.out_load && (i_cmd.out_sel == OUT_ENTRY)) begin
            r_prev_vld <= 1'b1;
            r_prev_key <= r_best_key;
            r_prev_pos <= r_best_pos;
            r_emit     <= emit_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OUT_ENTRY: begin
                    r_out.status      <= ST_OK;
                    r_out.key_out     <= r_best_key;
                    r_out.system_out  <= r_best_sys;
                    r_out.entry_valid <= 1'b1;
                    r_out.last        <= (emit_next == r_take);
                end
                OUT_MARK: begin
                    r_out.status      <= ST_NONE;
                    r_out.key_out     <= '0;
                    r_out.system_out  <= '0;
                    r_out.entry_valid <= 1'b0;
                    r_out.last        <= 1'b1;
                end
                default: begin
                    r_out.status      <= r_status;
                    r_out.key_out     <= '0;
                    r_out.system_out  <= '0;
                    r_out.entry_valid <= 1'b0;
                    r_out.last        <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/sorted_range_query_table.sv -----
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_out)
//
// one transaction at a time; per command:
//   add, unused command, rejected remove: decode, then load the result register
//   remove at index k: entries above k move down one place, one store shift per cycle
//   query returning t entries: one counting pass then one selection pass per entry,
//   each bound by the single store read port
// synchronous active-low reset clears the entry count and control; store contents stay
// a stalled output holds its result register and the next result waits behind it
module sorted_range_query_table #(
    parameter int CAPACITY = srqt_pkg::SRQT_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  srqt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output srqt_pkg::t_out o_out_data
);
    import srqt_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: decode, store shift, count pass, selection passes, result hand-off
    srqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: entry store, scan pipeline, range and order compares, result register
    srqt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hw/rtl/srqt_checker.sv -----
module srqt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input srqt_pkg::t_out i_out_data
);
    import srqt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // one transaction in flight: not ready right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.entry_valid |-> i_out_data.status == ST_OK)
        else $error("entry result with error status");

    // results without an entry are single and zero filled
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.entry_valid |->
            i_out_data.last && i_out_data.key_out == '0 && i_out_data.system_out == '0)
        else $error("plain result not last or not zero");

    // an entry result that is not last is followed by another entry, either
    // still being selected or already loaded in the result register
    a_entry_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last |=>
            !i_in_ready || (i_out_valid && i_out_data.entry_valid))
        else $error("query ended before last entry");

endmodule

bind sorted_range_query_table srqt_checker u_srqt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ----- sim/tb.sv -----
module tb;
    import srqt_pkg::*;

    // clock, reset and the two channels; every input is known from time zero
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic out_valid;
    logic in_ready;
    t_out out_data;

    localparam logic [KEY_W-1:0] KEY_TOP  = '1;
    localparam logic [KEY_W-1:0] KEY_NINE = 48'h9_0000;
    localparam logic [KEY_W-1:0] KEY_ONE  = 48'h1_0000;

    // one line of the directed table; reps > 1 repeats the add with shifted key and id
    typedef struct {
        t_in        cmd;
        int         reps;
        bit         has_ack;
        logic [1:0] ack_status;
    } t_cmd_row;

    // shadow copy of the table contents
    logic [KEY_W-1:0] tbl_key [SRQT_CAPACITY];
    logic [SYS_W-1:0] tbl_sys [SRQT_CAPACITY];
    int               tbl_count = 0;

    // results of the last command applied to the shadow table
    t_out step_res [MAX_RESULTS];
    int   step_n;

    // results still owed by the block, oldest first
    t_out replies_due [$];

    t_cmd_row         rows [$];
    logic [KEY_W-1:0] key_pool [6];
    int               mismatches   = 0;
    int               results_seen = 0;
    bit               burst        = 1'b0;
    bit               held         = 1'b0;

    sorted_range_query_table DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // watchdog against a hung handshake or lost results
    initial begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

    // single-result acknowledge: no entry, last set
    function automatic t_out ack_word(logic [1:0] st);
        return '{status: st, key_out: '0, system_out: '0, entry_valid: 1'b0, last: 1'b1};
    endfunction

    // apply one command to the shadow table and list the results it gives
    function automatic void apply_table_cmd(t_in c);
        logic [KEY_W-1:0] mk [SRQT_CAPACITY];
        logic [SYS_W-1:0] ms [SRQT_CAPACITY];
        logic [KEY_W-1:0] k;
        logic [SYS_W-1:0] s;
        int               i;
        int               j;
        int               n;
        int               take;
        n      = 0;
        step_n = 1;
        case (c.func)
            FUNC_ADD: begin
                if (tbl_count >= SRQT_CAPACITY) begin
                    step_res[0] = ack_word(ST_FULL);
                end else begin
                    tbl_key[tbl_count] = c.time_key;
                    tbl_sys[tbl_count] = c.origin_id;
                    tbl_count++;
                    step_res[0] = ack_word(ST_OK);
                end
            end
            FUNC_REMOVE: begin
                if (int'(c.entry_index) >= tbl_count) begin
                    step_res[0] = ack_word(ST_BAD_INDEX);
                end else begin
                    // close the gap, younger entries move down one place
                    for (i = int'(c.entry_index); i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_sys[i] = tbl_sys[i+1];
                    end
                    tbl_count--;
                    step_res[0] = ack_word(ST_OK);
                end
            end
            FUNC_QUERY: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_key[i] >= c.range_start && tbl_key[i] <= c.range_end) begin
                        mk[n] = tbl_key[i];
                        ms[n] = tbl_sys[i];
                        n++;
                    end
                end
                // insertion sort, strict compare keeps equal keys in stored order
                for (i = 1; i < n; i++) begin
                    k = mk[i];
                    s = ms[i];
                    j = i;
                    while (j > 0 && mk[j-1] > k) begin
                        mk[j] = mk[j-1];
                        ms[j] = ms[j-1];
                        j--;
                    end
                    mk[j] = k;
                    ms[j] = s;
                end
                take = n;
                if (take > int'(c.result_limit)) take = int'(c.result_limit);
                if (take > MAX_RESULTS) take = MAX_RESULTS;
                if (take == 0) begin
                    step_res[0] = ack_word(ST_NONE);
                end else begin
                    for (i = 0; i < take; i++) begin
                        step_res[i] = '{status: ST_OK, key_out: mk[i], system_out: ms[i],
                                        entry_valid: 1'b1, last: (i == take - 1)};
                    end
                    step_n = take;
                end
            end
            default: step_res[0] = ack_word(ST_OK);
        endcase
    endfunction

    function automatic t_cmd_row dir_row(logic [1:0] f, logic [KEY_W-1:0] key,
                                         logic [SYS_W-1:0] sys, logic [IDX_IN_W-1:0] idx,
                                         logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi,
                                         logic [LIMIT_W-1:0] lim, int reps, bit has_ack,
                                         logic [1:0] st);
        t_cmd_row r;
        r.cmd        = '{func: f, time_key: key, origin_id: sys, entry_index: idx,
                         range_start: lo, range_end: hi, result_limit: lim};
        r.reps       = reps;
        r.has_ack    = has_ack;
        r.ack_status = st;
        return r;
    endfunction

    // idle length: mostly none or short, now and then long, none at all in a burst
    function automatic int idle_len();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 15);
        if (r < 7) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // keys lean on a small pool so that queries hit and equal keys show up
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return KEY_TOP;
        if (r < 4) return rand_key();
        return key_pool[$urandom_range(0, 5)];
    endfunction

    // random command shaped by the current fill of the shadow table
    function automatic t_in random_cmd();
        t_in              c;
        logic [KEY_W-1:0] t;
        int               r;
        // unused fields carry noise too
        c.time_key     = rand_key();
        c.origin_id    = 16'($urandom);
        c.entry_index  = 8'($urandom);
        c.range_start  = rand_key();
        c.range_end    = rand_key();
        c.result_limit = LIMIT_W'($urandom_range(0, 64));
        r = $urandom_range(0, 99);
        if (tbl_count < 6) begin
            c.func = (r < 55) ? FUNC_ADD : (r < 80) ? FUNC_QUERY : (r < 95) ? FUNC_REMOVE
                                                                            : FUNC_NONE;
        end else begin
            c.func = (r < 35) ? FUNC_ADD : (r < 73) ? FUNC_QUERY : (r < 95) ? FUNC_REMOVE
                                                                            : FUNC_NONE;
        end
        case (c.func)
            FUNC_ADD: c.time_key = pick_key();
            FUNC_REMOVE: begin
                if (tbl_count > 0 && $urandom_range(0, 99) < 85)
                    c.entry_index = IDX_IN_W'($urandom_range(0, tbl_count - 1));
                else
                    c.entry_index = IDX_IN_W'($urandom_range(tbl_count, 255));
            end
            FUNC_QUERY: begin
                r = $urandom_range(0, 7);
                if (r == 0) begin
                    c.range_start = '0;
                    c.range_end   = KEY_TOP;
                end else if (r > 1) begin
                    c.range_start = pick_key();
                    c.range_end   = pick_key();
                    // mostly ordered bounds, sometimes left inverted
                    if (c.range_start > c.range_end && $urandom_range(0, 7) != 0) begin
                        t             = c.range_start;
                        c.range_start = c.range_end;
                        c.range_end   = t;
                    end
                end
                r = $urandom_range(0, 7);
                if (r == 0) c.result_limit = '0;
                else if (r == 1) c.result_limit = LIMIT_W'(64);
                else if (r == 2) c.result_limit = LIMIT_W'($urandom_range(1, 3));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic flag_error(string msg);
        if (mismatches < 100) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // offer one transaction, hold it until accepted, then book its results
    task automatic send_cmd(t_in c, bit has_ack, logic [1:0] ack_status);
        int k;
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
        apply_table_cmd(c);
        if (has_ack) begin
            replies_due.push_back(ack_word(ack_status));
        end else begin
            for (k = 0; k < step_n; k++) replies_due.push_back(step_res[k]);
        end
    endtask

    // lower valid for a random gap after an accepted transaction
    task automatic sender_gap();
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // output side: random stalls, one long hold once traffic is well under way
    initial begin : receiver
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            if (!held && results_seen >= 120) begin
                // long hold, the sender keeps offering so the block backs up
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each accepted result with the oldest one owed
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                flag_error($sformatf("result with nothing owed: %p", out_data));
            end else begin
                want = replies_due.pop_front();
                if (out_data.status !== want.status)
                    flag_error($sformatf("status got %0d want %0d", out_data.status,
                                         want.status));
                if (out_data.key_out !== want.key_out)
                    flag_error($sformatf("key_out got %h want %h", out_data.key_out,
                                         want.key_out));
                if (out_data.system_out !== want.system_out)
                    flag_error($sformatf("system_out got %h want %h", out_data.system_out,
                                         want.system_out));
                if (out_data.entry_valid !== want.entry_valid)
                    flag_error($sformatf("entry_valid got %b want %b", out_data.entry_valid,
                                         want.entry_valid));
                if (out_data.last !== want.last)
                    flag_error($sformatf("last got %b want %b", out_data.last, want.last));
            end
        end
    end

    initial begin : stimulus
        t_in c;
        int  i;
        int  r;
        int  item;

        // directed table: empty table, extremes, full table, stable sort, bad indexes
        rows.push_back(dir_row(FUNC_QUERY, '0, '0, '0, '0, KEY_TOP, 7'd64, 1, 1'b1,
                               ST_NONE));
        rows.push_back(dir_row(FUNC_REMOVE, '0, '0, '0, '0, '0, '0, 1, 1'b1, ST_BAD_INDEX));
        rows.push_back(dir_row(FUNC_NONE, KEY_TOP, '1, '1, KEY_TOP, '0, '1, 1, 1'b1, ST_OK));
        rows.push_back(dir_row(FUNC_ADD, '0, 16'hFFFF, '0, '0, '0, '0, 1, 1'b1, ST_OK));
        rows.push_back(dir_row(FUNC_ADD, KEY_TOP, '0, '0, '0, '0, '0, 1, 1'b1, ST_OK));
        // fourteen adds in descending pairs of equal keys fill the table
        rows.push_back(dir_row(FUNC_ADD, KEY_NINE, 16'h0100, '0, '0, '0, '0, 14, 1'b1,
                               ST_OK));
        rows.push_back(dir_row(FUNC_ADD, 48'h1234, 16'h0001, '0, '0, '0, '0, 1, 1'b1,
                               ST_FULL));
        // whole range on a full table gives the longest answer
        rows.push_back(dir_row(FUNC_QUERY, '0, '0, '0, '0, KEY_TOP, 7'd64, 1, 1'b0, ST_OK));
        rows.push_back(dir_row(FUNC_QUERY, '0, '0, '0, '0, KEY_TOP, '0, 1, 1'b1, ST_NONE));
        rows.push_back(dir_row(FUNC_QUERY, '0, '0, '0, KEY_TOP, '0, 7'd64, 1, 1'b1,
                               ST_NONE));
        // single key held twice, order of storage must survive
        rows.push_back(dir_row(FUNC_QUERY, '0, '0, '0, 48'h7_0000, 48'h7_0000, 7'd64, 1,
                               1'b0, ST_OK));
        rows.push_back(dir_row(FUNC_REMOVE, '0, '0, 8'd7, '0, '0, '0, 1, 1'b1, ST_OK));
        rows.push_back(dir_row(FUNC_REMOVE, '0, '0, 8'd255, '0, '0, '0, 1, 1'b1,
                               ST_BAD_INDEX));

        for (i = 0; i < 6; i++)
            key_pool[i] = (i < 3) ? {24'h0, 24'($urandom)} : rand_key();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n]) begin
            for (r = 0; r < rows[n].reps; r++) begin
                c           = rows[n].cmd;
                c.time_key  = c.time_key - KEY_ONE * (r / 2);
                c.origin_id = c.origin_id + SYS_W'(r);
                send_cmd(c, rows[n].has_ack, rows[n].ack_status);
                sender_gap();
            end
        end

        for (item = 0; item < 145; item++) begin
            if (item == 60) begin
                // drain completely before going on
                in_valid <= 1'b0;
                while (replies_due.size() != 0) @(posedge clk);
            end
            burst = (item >= 100 && item < 130);
            send_cmd(random_cmd(), 1'b0, ST_OK);
            sender_gap();
        end

        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        // room for any stray result to show up
        repeat (400) @(posedge clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
